// ===== design/cbc_pkg.sv =====
// Shared types and constants of the cartridge bank controller.
package cbc_pkg;

	localparam int RAM_BANKS_DEF      = 4;
	localparam int RAM_BANK_BYTES_DEF = 8192;
	localparam int ROM_ADDR_W         = 22;
	localparam int CFG_ADDR_W         = 3;

	localparam logic       ACT_READ       = 1'b0;
	localparam logic       ACT_WRITE      = 1'b1;
	localparam logic [7:0] RAM_ENABLE_KEY = 8'h0A;
	localparam logic [7:0] CLOCK_BANK_LO  = 8'h08;
	localparam logic [7:0] CLOCK_BANK_HI  = 8'h0C;
	localparam logic [2:0] RAM_WINDOW     = 3'b101;
	localparam logic       CFG_MBC_ENABLED = 1'b0;

	typedef enum logic [1:0] {
		TGT_NONE  = 2'd0,
		TGT_ROM   = 2'd1,
		TGT_RAM   = 2'd2,
		TGT_CLOCK = 2'd3
	} target_t;

	typedef enum logic [1:0] {
		REG_RAM_ENABLE = 2'd0,
		REG_ROM_LOW    = 2'd1,
		REG_BANK_HIGH  = 2'd2,
		REG_MODE       = 2'd3
	} reg_sel_t;

	typedef struct packed {
		logic       action;
		logic [15:0] address;
		logic [7:0] write_data;
	} req_t;

	typedef struct packed {
		target_t                 target;
		logic [ROM_ADDR_W-1:0]   rom_address;
		logic [7:0]              read_data;
		logic                    ram_enable_flag;
	} rsp_t;

	typedef struct packed {
		target_t               target;
		logic [ROM_ADDR_W-1:0] rom_address;
		logic                  ram_rd;
		logic                  ram_wr;
		logic                  ram_enable_flag;
	} dec_t;

endpackage

// ===== design/cbc_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
module cbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/cbc_bank_regs.sv =====
// Bank registers and access decode of the cartridge bank controller.
module cbc_bank_regs #(
	parameter int RAM_BANKS      = cbc_pkg::RAM_BANKS_DEF,
	parameter int RAM_BANK_BYTES = cbc_pkg::RAM_BANK_BYTES_DEF,
	localparam int RAM_AW        = $clog2(RAM_BANKS * RAM_BANK_BYTES)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic               mbc_enabled,
	input  cbc_pkg::req_t      req,
	output cbc_pkg::dec_t      dec,
	output logic [RAM_AW-1:0]  ram_addr
);

	localparam int BANK_W = (RAM_BANKS > 1) ? $clog2(RAM_BANKS) : 1;

	logic [7:0] rom_bank_q;
	logic [7:0] ram_bank_q;
	logic [7:0] mode_q;
	logic       ram_enable_q;
	logic [7:0] rom_bank_d;
	logic [7:0] ram_bank_d;
	logic [7:0] mode_d;
	logic       ram_enable_d;
	logic       wr;
	logic [13:0] offset;
	logic [4:0] low_bits;

	assign wr = (req.action == cbc_pkg::ACT_WRITE);

	always_comb begin
		offset = {1'b0, req.address[12:0]};
		for (int i = 0; i < 3; i++) begin
			if (offset >= 14'(RAM_BANK_BYTES)) begin
				offset = offset - 14'(RAM_BANK_BYTES);
			end
		end
	end

	assign ram_addr = RAM_AW'(ram_bank_q[BANK_W-1:0]) * RAM_AW'(RAM_BANK_BYTES)
		+ RAM_AW'(offset);

	assign low_bits = (req.write_data == 8'd0) ? 5'd1 : req.write_data[4:0];

	always_comb begin
		rom_bank_d   = rom_bank_q;
		ram_bank_d   = ram_bank_q;
		mode_d       = mode_q;
		ram_enable_d = ram_enable_q;
		if (mbc_enabled && wr && !req.address[15]) begin
			unique case (cbc_pkg::reg_sel_t'(req.address[14:13]))
				cbc_pkg::REG_RAM_ENABLE: begin
					ram_enable_d = (req.write_data == cbc_pkg::RAM_ENABLE_KEY);
				end
				cbc_pkg::REG_ROM_LOW: begin
					rom_bank_d = {rom_bank_q[7:5], low_bits};
				end
				cbc_pkg::REG_BANK_HIGH: begin
					if (mode_q != 8'd0) begin
						ram_bank_d = req.write_data;
					end else begin
						rom_bank_d = {req.write_data[2:0], rom_bank_q[4:0]};
					end
				end
				cbc_pkg::REG_MODE: begin
					mode_d = req.write_data;
				end
				default: begin
					mode_d = mode_q;
				end
			endcase
		end
	end

	always_comb begin
		dec                 = '0;
		dec.target          = cbc_pkg::TGT_NONE;
		dec.ram_enable_flag = ram_enable_d;
		if (!mbc_enabled) begin
			if (!wr && !req.address[15]) begin
				dec.target      = cbc_pkg::TGT_ROM;
				dec.rom_address = cbc_pkg::ROM_ADDR_W'(req.address);
			end
		end else if (!req.address[15]) begin
			if (!wr) begin
				dec.target = cbc_pkg::TGT_ROM;
				if (req.address[14]) begin
					dec.rom_address = {rom_bank_q, req.address[13:0]};
				end else begin
					dec.rom_address = cbc_pkg::ROM_ADDR_W'(req.address);
				end
			end
		end else if (req.address[15:13] == cbc_pkg::RAM_WINDOW) begin
			if ({1'b0, ram_bank_q} < 9'(RAM_BANKS)) begin
				dec.target = cbc_pkg::TGT_RAM;
				dec.ram_rd = !wr;
				dec.ram_wr = wr;
			end else if (ram_bank_q >= cbc_pkg::CLOCK_BANK_LO
				&& ram_bank_q <= cbc_pkg::CLOCK_BANK_HI) begin
				dec.target = cbc_pkg::TGT_CLOCK;
			end else begin
				dec.target = cbc_pkg::TGT_RAM;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_bank_q   <= '0;
			ram_bank_q   <= '0;
			mode_q       <= '0;
			ram_enable_q <= 1'b0;
		end else if (accept) begin
			rom_bank_q   <= rom_bank_d;
			ram_bank_q   <= ram_bank_d;
			mode_q       <= mode_d;
			ram_enable_q <= ram_enable_d;
		end
	end

endmodule

// ===== design/cartridge_bank_controller.sv =====
// Top level of the cartridge bank controller: handshake pipeline, RAM and config port.
// An accepted item is held in stage one, then in the output register that presents its result.
// One item is taken per cycle unless stalled; each item uses the single RAM port at most once.
// A stalled result holds the pipeline, and the RAM read data is held until it is taken.
// Reset clears the bank, mode and RAM-enable registers and sets mbc_enabled to one.
// Cart RAM contents are not cleared by reset and read back only after being written.
module cartridge_bank_controller #(
	parameter int RAM_BANKS      = cbc_pkg::RAM_BANKS_DEF,
	parameter int RAM_BANK_BYTES = cbc_pkg::RAM_BANK_BYTES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  cbc_pkg::req_t                req,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output cbc_pkg::rsp_t                rsp,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [cbc_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	localparam int RAM_DEPTH = RAM_BANKS * RAM_BANK_BYTES;
	localparam int RAM_AW    = $clog2(RAM_DEPTH);

	logic                mbc_enabled_q;
	logic                accept;
	logic                s1_go;
	logic                s1_valid_q;
	cbc_pkg::dec_t       dec;
	cbc_pkg::dec_t       dec_s1;
	logic [RAM_AW-1:0]   ram_addr;
	logic [7:0]          ram_rdata;
	logic                out_valid_q;
	cbc_pkg::rsp_t       out_q;

	assign pready = 1'b1;
	assign prdata = (paddr[cbc_pkg::CFG_ADDR_W-1] == cbc_pkg::CFG_MBC_ENABLED)
		? {31'd0, mbc_enabled_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mbc_enabled_q <= 1'b1;
		end else if (psel && penable && pwrite && pready
			&& paddr[cbc_pkg::CFG_ADDR_W-1] == cbc_pkg::CFG_MBC_ENABLED) begin
			mbc_enabled_q <= pwdata[0];
		end
	end

	assign s1_go     = s1_valid_q && (!out_valid_q || rsp_ready);
	assign req_ready = !s1_valid_q || s1_go;
	assign accept    = req_valid && req_ready;

	cbc_bank_regs #(
		.RAM_BANKS      (RAM_BANKS),
		.RAM_BANK_BYTES (RAM_BANK_BYTES)
	) u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.mbc_enabled (mbc_enabled_q),
		.req         (req),
		.dec         (dec),
		.ram_addr    (ram_addr)
	);

	cbc_ram #(
		.WIDTH (8),
		.DEPTH (RAM_DEPTH)
	) u_ram (
		.clk   (clk),
		.en    (accept && (dec.ram_rd || dec.ram_wr)),
		.we    (dec.ram_wr),
		.addr  (ram_addr),
		.wdata (req.write_data),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_go) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_go) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dec_s1 <= dec;
		end
		if (s1_go) begin
			out_q.target          <= dec_s1.target;
			out_q.rom_address     <= dec_s1.rom_address;
			out_q.read_data       <= dec_s1.ram_rd ? ram_rdata : 8'd0;
			out_q.ram_enable_flag <= dec_s1.ram_enable_flag;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	a_data_only_ram: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.target != cbc_pkg::TGT_RAM |-> rsp.read_data == 8'd0)
		else $error("read data without a cart RAM target");

	a_addr_only_rom: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.target != cbc_pkg::TGT_ROM |-> rsp.rom_address == '0)
		else $error("ROM address without a ROM target");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && out_valid_q && !rsp_ready |-> !req_ready)
		else $error("item accepted while both stages are held");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		s1_go |=> rsp_valid)
		else $error("stage one advanced without a result");

endmodule
